FILE: src/att_pkg.sv
// Shared types and constants for the advertiser tracking table.
// Holds the item structs, the table record, the control state enum and the
// command/status structs that join att_ctrl and att_datapath.
package att_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int MAX_RESULTS       = 16;
   localparam int CNT_W             = 5;
   localparam int SLOT_W            = 4;
   localparam int STALE_W           = 32;

   localparam logic [STALE_W-1:0] STALE_LIMIT_RST = 32'd10000;
   localparam logic [2:0]         SCAN_RESPONSE   = 3'd4;

   typedef struct packed {
      logic              mode;
      logic [2:0]        event_type;
      logic [1:0]        address_kind;
      logic [47:0]       device_address;
      logic signed [7:0] signal_dbm;
      logic [31:0]       now_ms;
   } req_item_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              entry_valid;
      logic              is_new;
      logic [47:0]       entry_address;
      logic              entry_kind;
      logic [2:0]        entry_event;
      logic [15:0]       packet_count;
      logic signed [7:0] last_signal;
      logic signed [7:0] peak_signal;
      logic [31:0]       first_seen_ms;
      logic              last_of_run;
   } rsp_item_type;

   // one stored advertiser
   typedef struct packed {
      logic [47:0]       addr;
      logic              kind;
      logic [2:0]        evt;
      logic [31:0]       first;
      logic [31:0]       last;
      logic [15:0]       packets;
      logic signed [7:0] rssi;
      logic signed [7:0] peak;
   } rec_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_FLUSH
   } ctl_state_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic commit;
      logic flush;
   } ctl_cmd_type;

   typedef struct packed {
      logic mode;
      logic scan_done;
      logic out_free;
   } ctl_status_type;

endpackage

FILE: src/att_ctrl.sv
// Sequencer for the advertiser tracking table: accept, scan, commit or flush.
// Depends on att_pkg; drives commands into att_datapath and reads its status.
module att_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  att_pkg::ctl_status_type status,
   output att_pkg::ctl_cmd_type    cmd
);
   import att_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = status.mode ? ST_FLUSH : ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.commit = 1'b1;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            cmd.flush = 1'b1;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: src/att_datapath.sv
// Datapath of the advertiser tracking table: record memory, used bits, scan
// pipeline, victim tracking, sweep hold register and result register.
// Depends on att_pkg; commanded by att_ctrl.
module att_datapath #(
   parameter int TABLE_ENTRIES = att_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  att_pkg::req_item_type        req_payload,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [att_pkg::STALE_W-1:0]  csr_data,
   input  att_pkg::ctl_cmd_type         cmd,
   output att_pkg::ctl_status_type      status,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output att_pkg::rsp_item_type        rsp_payload
);
   import att_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   function automatic rsp_item_type make_rsp(rec_type r, logic [SLOT_W-1:0] s,
                                             logic fresh, logic last);
      rsp_item_type o;
      o.slot          = s;
      o.entry_valid   = 1'b1;
      o.is_new        = fresh;
      o.entry_address = r.addr;
      o.entry_kind    = r.kind;
      o.entry_event   = r.evt;
      o.packet_count  = r.packets;
      o.last_signal   = r.rssi;
      o.peak_signal   = r.peak;
      o.first_seen_ms = r.first;
      o.last_of_run   = last;
      return o;
   endfunction

   function automatic rsp_item_type empty_rsp();
      rsp_item_type o;
      o             = '0;
      o.last_of_run = 1'b1;
      return o;
   endfunction

   // record memory and its registered read port
   rec_type rec_mem [TABLE_ENTRIES];
   rec_type rd_rec_ff;

   req_item_type             req_ff, req_in;
   logic [STALE_W-1:0]       stale_limit_ff, stale_limit_in;
   logic [TABLE_ENTRIES-1:0] used_ff, used_in;
   logic [IDX_W-1:0]         issue_idx_ff, issue_idx_in;
   logic                     issue_more_ff, issue_more_in;
   logic                     s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0]         s1_idx_ff, s1_idx_in;
   logic                     hit_ff, hit_in;
   logic [IDX_W-1:0]         hit_idx_ff, hit_idx_in;
   rec_type                  hit_rec_ff, hit_rec_in;
   logic                     vic_set_ff, vic_set_in;
   logic                     vic_used_ff, vic_used_in;
   logic [IDX_W-1:0]         vic_idx_ff, vic_idx_in;
   logic [31:0]              vic_last_ff, vic_last_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]         pend_idx_ff, pend_idx_in;
   rec_type                  pend_rec_ff, pend_rec_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_item_type             rsp_item_ff, rsp_item_in;

   logic             kind_fold;
   logic             used_k;
   logic             match;
   logic [31:0]      age;
   logic             live;
   logic             out_free;
   logic             sweep;
   logic             step_ok;
   logic             at_end;
   logic             cnt_full;
   logic             advance;
   logic             rd_en;
   logic             vic_take;
   logic             drop;
   logic [IDX_W-1:0] target;
   rec_type          base;
   rec_type          new_rec;
   logic             wr_en;

   assign kind_fold = req_ff.address_kind[0];
   assign used_k    = used_ff[s1_idx_ff];
   assign match     = used_k && (rd_rec_ff.kind == kind_fold) &&
                      (rd_rec_ff.addr == req_ff.device_address);
   assign age       = req_ff.now_ms - rd_rec_ff.last;
   assign live      = used_k && !(age > stale_limit_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign sweep     = req_ff.mode;
   // a live entry in a sweep pushes the held one out, so it waits for room
   assign step_ok   = s1_valid_ff && !(sweep && live && pend_valid_ff && !out_free);
   assign at_end    = (s1_idx_ff == LAST_IDX);
   assign cnt_full  = ((count_ff + 1'b1) == CNT_W'(MAX_RESULTS));
   assign advance   = cmd.scan && (!s1_valid_ff || step_ok);
   assign rd_en     = advance && issue_more_ff;
   assign vic_take  = !vic_set_ff || !used_k ||
                      (vic_used_ff && (rd_rec_ff.last < vic_last_ff));

   // report commit: merge the item into the hit entry or a fresh one
   assign drop   = !hit_ff && (req_ff.event_type == SCAN_RESPONSE);
   assign target = hit_ff ? hit_idx_ff : vic_idx_ff;

   always_comb begin
      if (hit_ff) begin
         base = hit_rec_ff;
      end else begin
         base.addr    = req_ff.device_address;
         base.kind    = kind_fold;
         base.evt     = '0;
         base.first   = req_ff.now_ms;
         base.last    = req_ff.now_ms;
         base.packets = '0;
         base.rssi    = req_ff.signal_dbm;
         base.peak    = req_ff.signal_dbm;
      end
      new_rec         = base;
      new_rec.last    = req_ff.now_ms;
      new_rec.packets = (base.packets == '1) ? base.packets : base.packets + 1'b1;
      new_rec.rssi    = req_ff.signal_dbm;
      if ($signed(req_ff.signal_dbm) > $signed(base.peak)) begin
         new_rec.peak = req_ff.signal_dbm;
      end
      if (req_ff.event_type != SCAN_RESPONSE) begin
         new_rec.evt = req_ff.event_type;
      end
   end

   assign wr_en = cmd.commit && out_free && !drop;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_mem[target] <= new_rec;
      end
      if (rd_en) begin
         rd_rec_ff <= rec_mem[issue_idx_ff];
      end
   end

   always_comb begin
      req_in         = req_ff;
      stale_limit_in = stale_limit_ff;
      used_in        = used_ff;
      issue_idx_in   = issue_idx_ff;
      issue_more_in  = issue_more_ff;
      s1_valid_in    = s1_valid_ff;
      s1_idx_in      = s1_idx_ff;
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      hit_rec_in     = hit_rec_ff;
      vic_set_in     = vic_set_ff;
      vic_used_in    = vic_used_ff;
      vic_idx_in     = vic_idx_ff;
      vic_last_in    = vic_last_ff;
      pend_valid_in  = pend_valid_ff;
      pend_idx_in    = pend_idx_ff;
      pend_rec_in    = pend_rec_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_item_in    = rsp_item_ff;

      if (csr_valid && csr_ready) begin
         stale_limit_in = csr_data;
      end

      if (cmd.start) begin
         req_in        = req_payload;
         issue_idx_in  = '0;
         issue_more_in = 1'b1;
         s1_valid_in   = 1'b0;
         hit_in        = 1'b0;
         vic_set_in    = 1'b0;
         pend_valid_in = 1'b0;
         count_in      = '0;
      end

      // advance the read stage
      if (advance) begin
         s1_valid_in = issue_more_ff;
         if (issue_more_ff) begin
            s1_idx_in     = issue_idx_ff;
            issue_idx_in  = issue_idx_ff + 1'b1;
            issue_more_in = (issue_idx_ff != LAST_IDX);
         end
      end

      // compare stage
      if (cmd.scan && step_ok) begin
         if (!sweep) begin
            if (match) begin
               hit_in     = 1'b1;
               hit_idx_in = s1_idx_ff;
               hit_rec_in = rd_rec_ff;
            end else if (vic_take) begin
               vic_set_in  = 1'b1;
               vic_used_in = used_k;
               vic_idx_in  = s1_idx_ff;
               vic_last_in = rd_rec_ff.last;
            end
         end else if (used_k && !live) begin
            used_in[s1_idx_ff] = 1'b0;
         end else if (live) begin
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = make_rsp(pend_rec_ff, SLOT_W'(pend_idx_ff), 1'b0, 1'b0);
            end
            pend_valid_in = 1'b1;
            pend_idx_in   = s1_idx_ff;
            pend_rec_in   = rd_rec_ff;
            count_in      = count_ff + 1'b1;
         end
      end

      if (cmd.commit && out_free) begin
         rsp_valid_in = 1'b1;
         if (drop) begin
            rsp_item_in = empty_rsp();
         end else begin
            used_in[target] = 1'b1;
            rsp_item_in     = make_rsp(new_rec, SLOT_W'(target), !hit_ff, 1'b1);
         end
      end

      if (cmd.flush && out_free) begin
         rsp_valid_in = 1'b1;
         if (pend_valid_ff) begin
            rsp_item_in = make_rsp(pend_rec_ff, SLOT_W'(pend_idx_ff), 1'b0, 1'b1);
         end else begin
            rsp_item_in = empty_rsp();
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stale_limit_ff <= STALE_LIMIT_RST;
         used_ff        <= '0;
         issue_more_ff  <= 1'b0;
         s1_valid_ff    <= 1'b0;
         hit_ff         <= 1'b0;
         vic_set_ff     <= 1'b0;
         pend_valid_ff  <= 1'b0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stale_limit_ff <= stale_limit_in;
         used_ff        <= used_in;
         issue_more_ff  <= issue_more_in;
         s1_valid_ff    <= s1_valid_in;
         hit_ff         <= hit_in;
         vic_set_ff     <= vic_set_in;
         pend_valid_ff  <= pend_valid_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      req_ff       <= req_in;
      issue_idx_ff <= issue_idx_in;
      s1_idx_ff    <= s1_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_rec_ff   <= hit_rec_in;
      vic_used_ff  <= vic_used_in;
      vic_idx_ff   <= vic_idx_in;
      vic_last_ff  <= vic_last_in;
      pend_idx_ff  <= pend_idx_in;
      pend_rec_ff  <= pend_rec_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign status.mode      = sweep;
   assign status.scan_done = cmd.scan && step_ok &&
                             (sweep ? (at_end || (live && cnt_full)) : (match || at_end));
   assign status.out_free  = out_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_item_ff;

endmodule

FILE: src/advertiser_tracking_table_unit.sv
// Advertiser tracking table, top level.
// Request channel (req_valid / req_stall / req_payload) takes one item at a
// time: mode 0 is an advertising report, mode 1 a stale sweep and listing.
// Result channel (rsp_valid / rsp_stall / rsp_payload) gives one item per
// report, and for a sweep one item per live entry, at most MAX_RESULTS,
// the final one flagged by last_of_run (nothing live: a single empty item).
// csr_valid / csr_ready / csr_data write the stale limit in milliseconds.
// The table sits in a single-port record memory scanned one entry per
// cycle while no stall holds the scan; a report ends its scan early on a
// hit, and a sweep also waits while the receiver stalls.
// req_stall is high from accept until the last result is loaded; the next
// item can be taken while that result still waits in the output register.
// A stalled result holds, and the scan holds with it when a sweep has a
// further entry to list. Reset (synchronous) marks every entry unused and sets the
// stale limit to 10000 ms; no clearing pass is needed.
// Depends on att_pkg, att_ctrl and att_datapath.
module advertiser_tracking_table_unit #(
   parameter int TABLE_ENTRIES = att_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  att_pkg::req_item_type        req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output att_pkg::rsp_item_type        rsp_payload,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [att_pkg::STALE_W-1:0]  csr_data
);
   import att_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   assign csr_ready = 1'b1;

   att_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   att_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
